[hdl/mtss_pkg.sv]
package mtss_pkg;

  localparam int MaxModes = 16;
  localparam int IdxW = (MaxModes > 1) ? $clog2(MaxModes) : 1;
  localparam int CntW = $clog2(MaxModes + 1);
  localparam int ResetCount = (MaxModes < 3) ? MaxModes : 3;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] dpi_value;
    logic [7:0]  mode_tag;
    logic        last_entry;
  } in_t;

  typedef struct packed {
    logic [7:0]  selected_tag;
    logic [15:0] pixels_per_inch;
    logic [3:0]  selected_index;
    logic [4:0]  mode_total;
  } out_t;

  typedef struct packed {
    logic [15:0] res;
    logic [7:0]  tag;
  } entry_t;

  // table port: one write, one read, compare of the read entry against key
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] wr_idx;
    entry_t          wr_entry;
    logic [IdxW-1:0] rd_idx;
    logic [15:0]     key;
  } tbl_ctrl_t;

  typedef struct packed {
    entry_t rd_entry;
    logic   gt;
    logic   eq;
  } tbl_stat_t;

  typedef enum logic [1:0] {
    StIdle,
    StInsert,
    StMid,
    StPick
  } state_e;

  function automatic entry_t default_entry(input int k);
    entry_t e;
    e = '0;
    if (k == 0) begin
      e.res = 16'd100;
      e.tag = 8'd0;
    end else if (k == 1) begin
      e.res = 16'd300;
      e.tag = 8'd1;
    end else if (k == 2) begin
      e.res = 16'd600;
      e.tag = 8'd2;
    end
    return e;
  endfunction

endpackage

[hdl/mtss_table.sv]
module mtss_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mtss_pkg::tbl_ctrl_t   ctrl_i,
  output mtss_pkg::tbl_stat_t   stat_o
);

  mtss_pkg::entry_t mem_q [mtss_pkg::MaxModes];
  mtss_pkg::entry_t rd_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mtss_pkg::MaxModes; k++) begin
        mem_q[k] <= mtss_pkg::default_entry(k);
      end
    end else if (ctrl_i.we) begin
      mem_q[ctrl_i.wr_idx] <= ctrl_i.wr_entry;
    end
  end

  // single read port feeding the shared comparator
  assign rd_entry        = mem_q[ctrl_i.rd_idx];
  assign stat_o.rd_entry = rd_entry;
  assign stat_o.gt       = rd_entry.res > ctrl_i.key;
  assign stat_o.eq       = rd_entry.res == ctrl_i.key;

endmodule

[hdl/mode_table_sort_and_select.sv]
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i / in_stall_o   in_data_i  (mtss_pkg::in_t)
// out      out  out_valid_o / out_stall_i out_data_o (mtss_pkg::out_t)
//
// One item at a time; in_stall_o is high from acceptance until the item is done.
// Load: shifts entries up (up to fill) and inserts the item in order; a full
// table drops the item. A last load then takes the middle entry as key and scans.
// Query: scans entries downward from the top (up to count).
// Both run on one table read port and one comparator, one entry per cycle.
// Reset restores the three default modes; a pending result holds the end of the scan.
module mode_table_sort_and_select (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mtss_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mtss_pkg::out_t   out_data_o
);

  mtss_pkg::state_e state_q, state_d;
  mtss_pkg::in_t    item_q, item_d;
  logic [mtss_pkg::IdxW-1:0] pos_q, pos_d;
  logic [mtss_pkg::IdxW-1:0] idx_q, idx_d;
  logic [mtss_pkg::CntW-1:0] fill_q, fill_d;
  logic [mtss_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [15:0]               key_q, key_d;
  logic                      out_valid_q, out_valid_d;
  mtss_pkg::out_t            out_q, out_d;

  mtss_pkg::tbl_ctrl_t tbl_ctrl;
  mtss_pkg::tbl_stat_t tbl_stat;

  logic in_acc;
  logic out_free;
  logic room;
  logic shift_more;
  logic pick_more;

  mtss_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tbl_ctrl),
    .stat_o (tbl_stat)
  );

  assign in_acc     = in_valid_i && (state_q == mtss_pkg::StIdle);
  assign out_free   = !(out_valid_q && out_stall_i);
  assign room       = fill_q < mtss_pkg::CntW'(mtss_pkg::MaxModes);
  assign shift_more = (pos_q != '0) && (tbl_stat.gt || tbl_stat.eq);
  assign pick_more  = (idx_q != '0) && tbl_stat.gt;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtss_pkg::StIdle: begin
        if (in_acc) begin
          if (in_data_i.operation == mtss_pkg::OpQuery) begin
            state_d = mtss_pkg::StPick;
          end else if (room) begin
            state_d = mtss_pkg::StInsert;
          end else if (in_data_i.last_entry) begin
            state_d = mtss_pkg::StMid;
          end
        end
      end
      mtss_pkg::StInsert: begin
        if (!shift_more) begin
          state_d = item_q.last_entry ? mtss_pkg::StMid : mtss_pkg::StIdle;
        end
      end
      mtss_pkg::StMid: begin
        state_d = mtss_pkg::StPick;
      end
      mtss_pkg::StPick: begin
        if (!pick_more && out_free) begin
          state_d = mtss_pkg::StIdle;
        end
      end
      default: state_d = mtss_pkg::StIdle;
    endcase
  end

  // datapath and table control
  always_comb begin
    item_d      = item_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    tbl_ctrl          = '0;
    tbl_ctrl.key      = key_q;
    tbl_ctrl.rd_idx   = idx_q;

    unique case (state_q)
      mtss_pkg::StIdle: begin
        if (in_acc) begin
          item_d = in_data_i;
          key_d  = in_data_i.dpi_value;
          pos_d  = fill_q[mtss_pkg::IdxW-1:0];
          idx_d  = mtss_pkg::IdxW'(cnt_q - mtss_pkg::CntW'(1));
          if (in_data_i.operation == mtss_pkg::OpLoad && !room && in_data_i.last_entry) begin
            fill_d = '0;
          end
        end
      end
      mtss_pkg::StInsert: begin
        tbl_ctrl.rd_idx = pos_q - mtss_pkg::IdxW'(1);
        tbl_ctrl.we     = 1'b1;
        tbl_ctrl.wr_idx = pos_q;
        if (shift_more) begin
          tbl_ctrl.wr_entry = tbl_stat.rd_entry;
          pos_d             = pos_q - mtss_pkg::IdxW'(1);
        end else begin
          tbl_ctrl.wr_entry.res = item_q.dpi_value;
          tbl_ctrl.wr_entry.tag = item_q.mode_tag;
          cnt_d                 = fill_q + mtss_pkg::CntW'(1);
          fill_d                = item_q.last_entry ? '0 : fill_q + mtss_pkg::CntW'(1);
        end
      end
      mtss_pkg::StMid: begin
        tbl_ctrl.rd_idx = mtss_pkg::IdxW'(cnt_q >> 1);
        key_d           = tbl_stat.rd_entry.res;
        idx_d           = mtss_pkg::IdxW'(cnt_q - mtss_pkg::CntW'(1));
      end
      mtss_pkg::StPick: begin
        if (pick_more) begin
          idx_d = idx_q - mtss_pkg::IdxW'(1);
        end else if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.selected_tag    = tbl_stat.rd_entry.tag;
          out_d.pixels_per_inch = key_q;
          out_d.selected_index  = 4'(idx_q);
          out_d.mode_total      = 5'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtss_pkg::StIdle;
      fill_q      <= '0;
      cnt_q       <= mtss_pkg::CntW'(mtss_pkg::ResetCount);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    key_q  <= key_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = state_q != mtss_pkg::StIdle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mtss_pkg::StPick |-> {1'b0, idx_q} < {1'b0, cnt_q})
    else $error("scan index beyond table");

  a_count_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mtss_pkg::CntW'(mtss_pkg::MaxModes) && cnt_q != '0 &&
    cnt_q <= mtss_pkg::CntW'(mtss_pkg::MaxModes))
    else $error("fill or count out of range");

  a_result_from_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == mtss_pkg::StPick))
    else $error("result launched outside scan");
`endif

endmodule
